### rtl/bpq_pkg.sv
// shared constants and types for the button press qualifier
package bpq_pkg;

  // level that means the button is down
  localparam logic PRESSED_LEVEL = 1'b0;

  // debounce time in ticks (60 ms at 20 ms a tick)
  localparam int unsigned TICK_MS      = 20;
  localparam int unsigned DEBOUNCE_MS  = 60;
  localparam int unsigned HELD_W       = 16;
  localparam logic [HELD_W-1:0] SHORT_TICKS = HELD_W'(DEBOUNCE_MS / TICK_MS);
  localparam logic [HELD_W-1:0] HELD_MAX    = {HELD_W{1'b1}};

  // event value and long press offset
  localparam int unsigned EVENT_W  = 4;
  localparam logic [EVENT_W-1:0] LONG_ADD = EVENT_W'(10);

  // configuration data and long press threshold
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned LONG_MS_RESET = 1000;
  localparam int unsigned LONG_TICKS_W = 12;
  localparam logic [LONG_TICKS_W-1:0] LONG_TICKS_RESET =
    LONG_TICKS_W'(LONG_MS_RESET / TICK_MS);

  // divide by the tick length: multiply by 2^20/20 rounded up, then shift
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_TICK =
    RECIP_W'(((1 << RECIP_SHIFT) + TICK_MS - 1) / TICK_MS);
  localparam int unsigned PROD_W = CFG_DATA_W + RECIP_W;

  // action modes
  typedef enum logic [1:0] {
    AM_PUSH   = 2'd0,
    AM_INVERT = 2'd1,
    AM_TOGGLE = 2'd2
  } action_mode_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTION_MODE       = 2'd0,
    REG_INPUT_MODE        = 2'd1,
    REG_LONG_PRESS_ENABLE = 2'd2,
    REG_LONG_PRESS_MS     = 2'd3
  } cfg_reg_t;

endpackage

### rtl/button_press_qualifier.sv
// Button debounce with short and long press qualification.
// One input item is one 20 ms tick of the button. The block takes one item
// every clock cycle while in_stall is low: the per-tick update is registered
// straight from the item into the state and result registers, so the rate is one
// item per cycle. An item gives zero or one result. in_stall rises only while
// a result sits in the result register and out_stall holds it there.
// Configuration writes are always taken (cfg_ready is high); the long press
// threshold in ticks is worked out when long_press_ms is written.
module button_press_qualifier
  import bpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input item
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   button_level,
  input  logic                   press_flag,
  // result item
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [EVENT_W-1:0]     event_value,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  action_mode_t            action_mode;
  logic                    input_mode;
  logic                    long_press_enable;
  logic [LONG_TICKS_W-1:0] long_ticks;

  // tick state
  logic                    last_level;
  logic                    held_flag;
  logic [HELD_W-1:0]       held_ticks;
  logic [EVENT_W-1:0]      stored_state;

  // next values
  logic                    last_level_next;
  logic                    held_flag_next;
  logic [HELD_W-1:0]       held_ticks_next;
  logic [EVENT_W-1:0]      stored_state_next;
  logic [EVENT_W-1:0]      event_next;
  logic                    fire;

  logic                    btn;
  logic [EVENT_W-1:0]      new_state;
  logic                    in_accept;
  logic                    cfg_write;
  logic [PROD_W-1:0]       ms_prod;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // long press milliseconds to ticks
  assign ms_prod = PROD_W'(cfg_data) * PROD_W'(RECIP_TICK);

  // per-tick update
  always_comb begin
    btn               = last_level;
    held_flag_next    = held_flag;
    held_ticks_next   = held_ticks;
    last_level_next   = last_level;
    stored_state_next = stored_state;
    new_state         = stored_state;

    // pick the level: sampled, or flipped by a press latch
    if (input_mode == 1'b0) begin
      btn = button_level;
    end else if (press_flag) begin
      btn             = ~last_level;
      held_flag_next  = 1'b1;
      held_ticks_next = SHORT_TICKS;
    end

    // count pressed ticks, saturating
    if (btn == PRESSED_LEVEL) begin
      if (held_flag_next) begin
        if (held_ticks_next != HELD_MAX) begin
          held_ticks_next = held_ticks_next + HELD_W'(1);
        end
      end else begin
        held_flag_next  = 1'b1;
        held_ticks_next = '0;
      end
    end

    // debounced level change forms a new state
    if ((btn != last_level) && (held_ticks_next >= SHORT_TICKS)) begin
      last_level_next = btn;
      held_flag_next  = 1'b0;
      case (action_mode)
        AM_PUSH: begin
          new_state = EVENT_W'(btn);
        end
        AM_INVERT: begin
          new_state         = {{(EVENT_W-1){1'b0}}, ~btn};
          stored_state_next = EVENT_W'(btn);
        end
        AM_TOGGLE: begin
          if (btn == PRESSED_LEVEL) begin
            new_state = (stored_state == '0) ? EVENT_W'(1) : '0;
          end
          held_ticks_next = '0;
        end
        default: begin
        end
      endcase
    end

    // event on a state change, long press adds its offset
    fire       = (new_state != stored_state_next);
    event_next = new_state;
    if (long_press_enable && (held_ticks_next >= HELD_W'(long_ticks))) begin
      event_next = new_state + LONG_ADD;
    end
    if (fire) begin
      stored_state_next = event_next;
    end
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      action_mode       <= AM_PUSH;
      input_mode        <= 1'b0;
      long_press_enable <= 1'b0;
      long_ticks        <= LONG_TICKS_RESET;
      last_level        <= 1'b1;
      held_flag         <= 1'b0;
      held_ticks        <= '0;
      stored_state      <= EVENT_W'(1);
    end else begin
      if (in_accept) begin
        last_level   <= last_level_next;
        held_flag    <= held_flag_next;
        held_ticks   <= held_ticks_next;
        stored_state <= stored_state_next;
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_ACTION_MODE: begin
            action_mode  <= action_mode_t'(cfg_data[1:0]);
            stored_state <= (action_mode_t'(cfg_data[1:0]) == AM_INVERT) ?
                            '0 : EVENT_W'(1);
          end
          REG_INPUT_MODE: begin
            input_mode <= cfg_data[0];
          end
          REG_LONG_PRESS_ENABLE: begin
            long_press_enable <= cfg_data[0];
          end
          REG_LONG_PRESS_MS: begin
            long_ticks <= ms_prod[RECIP_SHIFT +: LONG_TICKS_W];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && fire) begin
      event_value <= event_next;
    end
  end

endmodule

### rtl/bpq_checker.sv
// port-level checks for the button press qualifier, bound to the top level
module bpq_checker
  import bpq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [EVENT_W-1:0]     event_value
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_value))
    else $error("held result changed");

  // events are a state, or a state plus the long press offset
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_value == 4'd0) || (event_value == 4'd1) ||
                  (event_value == 4'd10) || (event_value == 4'd11))
    else $error("event value out of range");

  // the input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // no result appears without an accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall) && !(out_valid && out_stall) |=> !out_valid)
    else $error("result without an item");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_press_qualifier bpq_checker u_bpq_checker (.*);

### verif/button_press_qualifier_test.sv
// self-checking testbench for the button press qualifier
module button_press_qualifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpq_pkg::*;

  // action mode code that the block leaves unused
  localparam logic [1:0] AM_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT = 20;

  // tracks button state per tick and holds the expected events in order
  class press_scoreboard;
    logic [1:0]        amode;
    logic              latch_input;
    logic              long_enable;
    logic [15:0]       long_ms;
    logic              last_level;
    logic              held_flag;
    logic [HELD_W-1:0] held_ticks;
    logic [3:0]        stored_state;
    logic [3:0]        pending_events[$];
    int                mismatches;
    int                strays;
    int                events_checked;
    int                ticks_taken;
    int                reg_writes;

    function new();
      amode        = AM_PUSH;
      latch_input  = 1'b0;
      long_enable  = 1'b0;
      long_ms      = 16'(LONG_MS_RESET);
      last_level   = 1'b1;
      held_flag    = 1'b0;
      held_ticks   = '0;
      stored_state = 4'd1;
      mismatches   = 0;
      strays       = 0;
      events_checked = 0;
      ticks_taken  = 0;
      reg_writes   = 0;
    endfunction

    // register write as seen by the block
    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_ACTION_MODE: begin
          amode = data[1:0];
          stored_state = (amode == AM_INVERT) ? 4'd0 : 4'd1;
        end
        REG_INPUT_MODE:        latch_input = data[0];
        REG_LONG_PRESS_ENABLE: long_enable = data[0];
        REG_LONG_PRESS_MS:     long_ms = data;
        default: ;
      endcase
    endfunction

    // one accepted tick: update state, queue an event if the state moves
    function void note_tick(logic lvl, logic flg);
      logic        button;
      int unsigned nxt;
      button = last_level;
      nxt = stored_state;
      ticks_taken++;

      // pick the level from the sample or from the press latch
      if (!latch_input) begin
        button = lvl;
      end else if (flg) begin
        button = ~button;
        held_flag = 1'b1;
        held_ticks = SHORT_TICKS;
      end

      // count pressed ticks, saturating
      if (button == PRESSED_LEVEL && held_flag) begin
        if (held_ticks < HELD_MAX) held_ticks++;
      end else if (button == PRESSED_LEVEL) begin
        held_flag = 1'b1;
        held_ticks = '0;
      end

      // debounced level change forms the new state
      if (button != last_level && held_ticks >= SHORT_TICKS) begin
        last_level = button;
        held_flag = 1'b0;
        case (amode)
          AM_PUSH: nxt = button;
          AM_INVERT: begin
            nxt = (button == 1'b0) ? 1 : 0;
            stored_state = (nxt == 0) ? 4'd1 : 4'd0;
          end
          AM_TOGGLE: begin
            if (button == PRESSED_LEVEL) nxt = (stored_state == 4'd0) ? 1 : 0;
            held_ticks = '0;
          end
          default: ;
        endcase
      end

      // event on a change of state, long press adds its offset
      if (nxt != stored_state) begin
        if (long_enable && held_ticks >= long_ms / TICK_MS) nxt += LONG_ADD;
        stored_state = 4'(nxt);
        pending_events.push_back(4'(nxt));
      end
    endfunction

    // compare one event from the block with the oldest expected one
    function void check_event(logic [3:0] got);
      logic [3:0] want;
      if (pending_events.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("unexpected event_value %0d with nothing pending", got);
        return;
      end
      want = pending_events.pop_front();
      events_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches + strays <= 10)
          $display("event_value mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function int failures();
      return mismatches + strays + pending_events.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   button_level = 1'b1;
  logic                   press_flag = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [EVENT_W-1:0]     event_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  press_scoreboard sb = new();
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  int hold_request  = 0;
  int settings_used = 0;

  button_press_qualifier dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button_level (button_level),
    .press_flag   (press_flag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_value  (event_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // generous overall limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // results are checked before the item of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && !out_stall) sb.check_event(event_value);
      if (in_valid && in_stall === 1'b0) sb.note_tick(button_level, press_flag);
    end
  end

  // receiver stall: random, calm, or a counted long hold-off
  always @(negedge clk) begin
    static int hold_left = 0;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (receiver_calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // offer one tick, with random gaps first, and wait for it to be taken
  task automatic send_tick(input logic lvl, input logic flg);
    while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= lvl;
    press_flag   <= flg;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // one register write on the configuration channel
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // full setting while the block is idle
  task automatic configure(input logic [1:0] am, input logic im, input logic en,
                           input logic [15:0] ms);
    write_reg(REG_ACTION_MODE, CFG_DATA_W'(am));
    write_reg(REG_INPUT_MODE, CFG_DATA_W'(im));
    write_reg(REG_LONG_PRESS_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_LONG_PRESS_MS, ms);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // stop offering, wait for every pending event, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic press_release(input int down, input int up);
    repeat (down) send_tick(1'b0, $urandom_range(1));
    repeat (up) send_tick(1'b1, $urandom_range(1));
  endtask

  // mostly press and release sequences in level mode, random latch pulses otherwise
  task automatic random_ticks(input int count);
    int left;
    int down;
    int up;
    left = count;
    while (left > 0) begin
      if (sb.latch_input) begin
        send_tick($urandom_range(1), $urandom_range(99) < 40);
        left--;
      end else if ($urandom_range(99) < 20) begin
        send_tick($urandom_range(1), $urandom_range(1));
        left--;
      end else begin
        down = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        up   = $urandom_range(1, 6);
        press_release(down, up);
        left -= down + up;
      end
    end
  endtask

  initial begin
    logic [15:0] ms;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: bounces, two short presses, a real press and release
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    press_release(2, 1);
    press_release(3, 1);
    // receiver held off while the real press gives its event, so the input backs up
    hold_request = 80;
    press_release(6, 2);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    drain();

    // inverted, long press with a zero threshold
    configure(AM_INVERT, 1'b0, 1'b1, 16'd0);
    press_release(4, 2);
    random_ticks(50);
    drain();

    // toggle with zero threshold, receiver held off so the block backs up
    configure(AM_TOGGLE, 1'b0, 1'b1, 16'd19);
    hold_request = 80;
    random_ticks(50);
    drain();

    // unused action mode forms no state
    configure(AM_UNUSED, 1'b0, 1'b1, 16'd40);
    random_ticks(30);
    drain();

    // press latch input, push mode
    configure(AM_PUSH, 1'b1, 1'b1, 16'd100);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    random_ticks(50);
    drain();

    configure(AM_TOGGLE, 1'b1, 1'b0, 16'hFFFF);
    random_ticks(40);
    drain();

    configure(AM_INVERT, 1'b1, 1'b1, 16'd200);
    random_ticks(40);
    drain();

    // long press, no idling on either side
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    configure(AM_PUSH, 1'b0, 1'b1, 16'd600);
    press_release(40, 4);
    drain();
    sender_calm = 1'b0;
    receiver_calm = 1'b0;

    // random settings
    repeat (2) begin
      case ($urandom_range(3))
        0: ms = 16'd0;
        1: ms = 16'($urandom_range(0, 59));
        2: ms = 16'($urandom_range(60, 300));
        default: ms = 16'hFFFF;
      endcase
      configure($urandom_range(3), $urandom_range(1), $urandom_range(1), ms);
      random_ticks(50);
      drain();
    end

    repeat (10) @(negedge clk);
    $display("%0d ticks taken, %0d events checked", sb.ticks_taken, sb.events_checked);
    $display("%0d register writes over %0d settings, long hold and latch input included",
             sb.reg_writes, settings_used);
    if (sb.failures() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d stray events, %0d missing", sb.mismatches, sb.strays,
               sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
